// ===== rtl/core/led_matrix_scan_driver_defines.svh =====
// Assertion macros used by the port-level checker of the LED matrix scan driver.
`ifndef LED_MATRIX_SCAN_DRIVER_DEFINES_SVH
`define LED_MATRIX_SCAN_DRIVER_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define LMSD_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define LMSD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/lmsd_pkg.sv =====
// Types, constants and helper functions shared by the LED matrix scan driver.
package lmsd_pkg;

   localparam int LEVEL_WIDTH      = 8;
   localparam int ROW_ADDR_WIDTH   = 3;
   localparam int RGB_WIDTH        = 3;
   localparam int REQ_TDATA_WIDTH  = 40;
   localparam int RSP_TDATA_WIDTH  = 16;

   typedef enum logic {
      MODE_WRITE = 1'b0,
      MODE_TICK  = 1'b1
   } mode_type;

   typedef struct packed {
      logic [LEVEL_WIDTH-1:0] red;
      logic [LEVEL_WIDTH-1:0] green;
      logic [LEVEL_WIDTH-1:0] blue;
   } colour_type;

   // What a tick carries from the scan counters to the output stage.
   typedef struct packed {
      logic                      row_end;
      logic [ROW_ADDR_WIDTH-1:0] row_address;
      logic [LEVEL_WIDTH-1:0]    step;
   } tick_info_type;

   // Red in bit 2, green in bit 1, blue in bit 0; a component is lit when it
   // reaches the current brightness step.
   function automatic logic [RGB_WIDTH-1:0] threshold_bits(
      input colour_type             colour,
      input logic [LEVEL_WIDTH-1:0] step
   );
      logic [RGB_WIDTH-1:0] bits;
      bits[2] = (colour.red   >= step);
      bits[1] = (colour.green >= step);
      bits[0] = (colour.blue  >= step);
      return bits;
   endfunction

endpackage

// ===== rtl/core/lmsd_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module lmsd_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 256
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic                                      rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/lmsd_store_ctrl.sv =====
// Write port control for the two half-panel stores, including the clearing sweep.
module lmsd_store_ctrl import lmsd_pkg::*; #(
   parameter int PANEL_COLUMNS = 32,
   parameter int HALF_ROWS     = 8
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       write_accept,
   input  logic [4:0] pixel_row,
   input  logic [4:0] pixel_column,
   input  colour_type pixel_colour,
   output logic       clearing,
   output logic       upper_we,
   output logic       lower_we,
   output logic [($clog2(HALF_ROWS * PANEL_COLUMNS))-1:0] wr_addr,
   output colour_type wr_data
);

   localparam int DEPTH = HALF_ROWS * PANEL_COLUMNS;
   localparam int AW    = $clog2(DEPTH);

   logic          clearing_ff, clearing_in;
   logic [AW-1:0] clr_addr_ff, clr_addr_in;

   logic [6:0]    row_ext;
   logic [6:0]    half_row;
   logic          in_upper;
   logic          in_lower;
   logic          col_ok;
   logic [AW-1:0] pixel_addr;

   // Sweep every entry of both stores once after reset.
   always_comb begin
      clearing_in = clearing_ff;
      clr_addr_in = clr_addr_ff;
      if (clearing_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == AW'(DEPTH - 1)) begin
            clearing_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clearing_ff <= clearing_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   // Split the panel row into a half and a row within that half.
   always_comb begin
      row_ext    = {2'b00, pixel_row};
      in_upper   = (row_ext < 7'(HALF_ROWS));
      in_lower   = !in_upper && (row_ext < 7'(2 * HALF_ROWS));
      half_row   = in_upper ? row_ext : (row_ext - 7'(HALF_ROWS));
      col_ok     = ({4'b0000, pixel_column} < 9'(PANEL_COLUMNS));
      pixel_addr = AW'(half_row * PANEL_COLUMNS + pixel_column);
   end

   always_comb begin
      if (clearing_ff) begin
         upper_we = 1'b1;
         lower_we = 1'b1;
         wr_addr  = clr_addr_ff;
         wr_data  = '0;
      end else begin
         upper_we = write_accept && col_ok && in_upper;
         lower_we = write_accept && col_ok && in_lower;
         wr_addr  = pixel_addr;
         wr_data  = pixel_colour;
      end
   end

   assign clearing = clearing_ff;

endmodule

// ===== rtl/core/lmsd_scan_ctrl.sv =====
// Column, row and brightness step counters of the panel scan.
module lmsd_scan_ctrl import lmsd_pkg::*; #(
   parameter int PANEL_COLUMNS    = 32,
   parameter int HALF_ROWS        = 8,
   parameter int BRIGHTNESS_STEPS = 4
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          tick_accept,
   output logic [($clog2(HALF_ROWS * PANEL_COLUMNS))-1:0] rd_addr,
   output tick_info_type tick_info
);

   localparam int AW = $clog2(HALF_ROWS * PANEL_COLUMNS);
   localparam int CW = $clog2(PANEL_COLUMNS);
   localparam int RW = (HALF_ROWS > 1) ? $clog2(HALF_ROWS) : 1;
   localparam int SW = (BRIGHTNESS_STEPS > 1) ? $clog2(BRIGHTNESS_STEPS) : 1;

   logic [CW-1:0] column_ff, column_in;
   logic [RW-1:0] row_ff, row_in;
   logic [SW-1:0] step_ff, step_in;
   logic          last_column;

   assign last_column = (column_ff == CW'(PANEL_COLUMNS - 1));

   always_comb begin
      column_in = column_ff;
      row_in    = row_ff;
      step_in   = step_ff;
      if (tick_accept) begin
         if (!last_column) begin
            column_in = column_ff + 1'b1;
         end else begin
            column_in = '0;
            if (row_ff == RW'(HALF_ROWS - 1)) begin
               row_in = '0;
               if (step_ff == SW'(BRIGHTNESS_STEPS - 1)) begin
                  step_in = '0;
               end else begin
                  step_in = step_ff + 1'b1;
               end
            end else begin
               row_in = row_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff <= '0;
         row_ff    <= '0;
         step_ff   <= '0;
      end else begin
         column_ff <= column_in;
         row_ff    <= row_in;
         step_ff   <= step_in;
      end
   end

   // Both halves are read at the same offset within their own store.
   assign rd_addr = AW'(row_ff * PANEL_COLUMNS + column_ff);

   always_comb begin
      tick_info.row_end     = last_column;
      tick_info.row_address = last_column ? ROW_ADDR_WIDTH'(row_ff) : '0;
      tick_info.step        = LEVEL_WIDTH'(step_ff);
   end

endmodule

// ===== rtl/core/lmsd_pixel_out.sv =====
// Threshold compare and result register, with the read stage that feeds it.
module lmsd_pixel_out import lmsd_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      tick_accept,
   input  tick_info_type             tick_info,
   input  colour_type                upper_colour,
   input  colour_type                lower_colour,
   input  logic                      rsp_tready,
   output logic                      take_ok,
   output logic                      rsp_tvalid,
   output logic [RGB_WIDTH-1:0]      rsp_upper_rgb,
   output logic [RGB_WIDTH-1:0]      rsp_lower_rgb,
   output logic                      rsp_row_end,
   output logic [ROW_ADDR_WIDTH-1:0] rsp_row_address
);

   logic          read_valid_ff, read_valid_in;
   tick_info_type read_info_ff, read_info_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [RGB_WIDTH-1:0]      upper_rgb_ff, upper_rgb_in;
   logic [RGB_WIDTH-1:0]      lower_rgb_ff, lower_rgb_in;
   logic                      row_end_ff, row_end_in;
   logic [ROW_ADDR_WIDTH-1:0] row_address_ff, row_address_in;
   logic                      advance;

   // The read stage moves on whenever the result register is free or emptying.
   assign advance = !rsp_valid_ff || rsp_tready;
   assign take_ok = !read_valid_ff || advance;

   always_comb begin
      read_valid_in = tick_accept || (read_valid_ff && !advance);
      read_info_in  = tick_accept ? tick_info : read_info_ff;
      rsp_valid_in  = advance ? read_valid_ff : rsp_valid_ff;
      if (advance && read_valid_ff) begin
         upper_rgb_in   = threshold_bits(upper_colour, read_info_ff.step);
         lower_rgb_in   = threshold_bits(lower_colour, read_info_ff.step);
         row_end_in     = read_info_ff.row_end;
         row_address_in = read_info_ff.row_address;
      end else begin
         upper_rgb_in   = upper_rgb_ff;
         lower_rgb_in   = lower_rgb_ff;
         row_end_in     = row_end_ff;
         row_address_in = row_address_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         read_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         read_valid_ff <= read_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      read_info_ff   <= read_info_in;
      upper_rgb_ff   <= upper_rgb_in;
      lower_rgb_ff   <= lower_rgb_in;
      row_end_ff     <= row_end_in;
      row_address_ff <= row_address_in;
   end

   assign rsp_tvalid      = rsp_valid_ff;
   assign rsp_upper_rgb   = upper_rgb_ff;
   assign rsp_lower_rgb   = lower_rgb_ff;
   assign rsp_row_end     = row_end_ff;
   assign rsp_row_address = row_address_ff;

endmodule

// ===== rtl/core/led_matrix_scan_driver.sv =====
// An accepted tick item is held in the read stage and moves into the result register,
// which drives the result port, once that register is free or its result is taken.
// Throughput: one item per cycle, write or tick, unless req_tready is held low; the
// frame store's single read port per panel half and the one-deep read stage set this figure.
// Reset: synchronous; after it the block clears every entry of both half stores,
// with req_tready low throughout.
// Top level of the LED matrix scan driver.
module led_matrix_scan_driver import lmsd_pkg::*; #(
   parameter int PANEL_COLUMNS    = 32,
   parameter int HALF_ROWS        = 8,
   parameter int BRIGHTNESS_STEPS = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   // pixel_row[4:0], pixel_column[9:5], red_level[17:10], green_level[25:18],
   // blue_level[33:26], zero padding[39:34]
   input  logic [REQ_TDATA_WIDTH-1:0] req_tdata,
   // mode[0]: 0 writes one pixel, 1 is a scan tick
   input  logic                       req_tuser,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   // upper_rgb[2:0], lower_rgb[5:3], row_address[8:6], zero padding[15:9]
   output logic [RSP_TDATA_WIDTH-1:0] rsp_tdata,
   // row_end: this column completes the row (blank, set address, latch)
   output logic                       rsp_tlast
);

   // Each half of the panel has its own store, so that a tick can read the
   // upper and the lower pixel of a column in the same cycle. Both stores
   // are addressed as row-within-half times PANEL_COLUMNS plus column.
   localparam int DEPTH = HALF_ROWS * PANEL_COLUMNS;
   localparam int AW    = $clog2(DEPTH);

   logic          req_accept;
   logic          tick_accept;
   logic          write_accept;
   mode_type      req_mode;
   colour_type    pixel_colour;

   logic          clearing;
   logic          upper_we;
   logic          lower_we;
   logic [AW-1:0] wr_addr;
   colour_type    wr_data;

   logic [AW-1:0] rd_addr;
   tick_info_type tick_info;
   colour_type    upper_colour;
   colour_type    lower_colour;
   logic          take_ok;

   logic [RGB_WIDTH-1:0]      upper_rgb;
   logic [RGB_WIDTH-1:0]      lower_rgb;
   logic [ROW_ADDR_WIDTH-1:0] row_address;

   // Items are held off while the stores are cleared, and otherwise only when
   // a tick is waiting in the read stage behind a result that is not taken.
   assign req_tready   = !clearing && take_ok;
   assign req_accept   = req_tvalid && req_tready;
   assign req_mode     = mode_type'(req_tuser);
   assign tick_accept  = req_accept && (req_mode == MODE_TICK);
   assign write_accept = req_accept && (req_mode == MODE_WRITE);

   assign pixel_colour.red   = req_tdata[17:10];
   assign pixel_colour.green = req_tdata[25:18];
   assign pixel_colour.blue  = req_tdata[33:26];

   lmsd_store_ctrl #(
      .PANEL_COLUMNS (PANEL_COLUMNS),
      .HALF_ROWS     (HALF_ROWS)
   ) u_store_ctrl (
      .clock        (clock),
      .reset        (reset),
      .write_accept (write_accept),
      .pixel_row    (req_tdata[4:0]),
      .pixel_column (req_tdata[9:5]),
      .pixel_colour (pixel_colour),
      .clearing     (clearing),
      .upper_we     (upper_we),
      .lower_we     (lower_we),
      .wr_addr      (wr_addr),
      .wr_data      (wr_data)
   );

   lmsd_scan_ctrl #(
      .PANEL_COLUMNS    (PANEL_COLUMNS),
      .HALF_ROWS        (HALF_ROWS),
      .BRIGHTNESS_STEPS (BRIGHTNESS_STEPS)
   ) u_scan_ctrl (
      .clock       (clock),
      .reset       (reset),
      .tick_accept (tick_accept),
      .rd_addr     (rd_addr),
      .tick_info   (tick_info)
   );

   // A write lands at the edge where it is accepted, so a tick accepted in
   // the very next cycle already reads the new colour.
   lmsd_ram #(
      .WIDTH ($bits(colour_type)),
      .DEPTH (DEPTH)
   ) u_upper_store (
      .clock   (clock),
      .wr_en   (upper_we),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (tick_accept),
      .rd_addr (rd_addr),
      .rd_data (upper_colour)
   );

   lmsd_ram #(
      .WIDTH ($bits(colour_type)),
      .DEPTH (DEPTH)
   ) u_lower_store (
      .clock   (clock),
      .wr_en   (lower_we),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (tick_accept),
      .rd_addr (rd_addr),
      .rd_data (lower_colour)
   );

   // The store read registers and the latched tick information form the
   // read stage; the compare against the brightness step sits between it
   // and the result register.
   lmsd_pixel_out u_pixel_out (
      .clock           (clock),
      .reset           (reset),
      .tick_accept     (tick_accept),
      .tick_info       (tick_info),
      .upper_colour    (upper_colour),
      .lower_colour    (lower_colour),
      .rsp_tready      (rsp_tready),
      .take_ok         (take_ok),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_upper_rgb   (upper_rgb),
      .rsp_lower_rgb   (lower_rgb),
      .rsp_row_end     (rsp_tlast),
      .rsp_row_address (row_address)
   );

   assign rsp_tdata = {{(RSP_TDATA_WIDTH - 9){1'b0}}, row_address, lower_rgb, upper_rgb};

endmodule

// ===== rtl/core/lmsd_checker.sv =====
// Port-level checks on the LED matrix scan driver, bound to its top level.
`include "led_matrix_scan_driver_defines.svh"

module lmsd_checker import lmsd_pkg::*; (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_tready,
   input logic                       rsp_tvalid,
   input logic                       rsp_tready,
   input logic [RSP_TDATA_WIDTH-1:0] rsp_tdata,
   input logic                       rsp_tlast
);

   `LMSD_ASSERT_NOW(a_padding_zero, rsp_tvalid, rsp_tdata[15:9] == 7'd0, "result padding not zero")
   `LMSD_ASSERT_NOW(a_addr_only_at_row_end, rsp_tvalid && !rsp_tlast, rsp_tdata[8:6] == 3'd0, "row address driven without row end")
   `LMSD_ASSERT_NOW(a_clear_after_reset, $fell(reset), !req_tready && !rsp_tvalid, "items taken or results shown during clearing")
   `LMSD_ASSERT_NEXT(a_stall_holds, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast), "stalled result changed")

endmodule

bind led_matrix_scan_driver lmsd_checker u_lmsd_checker (.*);

// ===== dv/led_matrix_scan_driver_checker.sv =====
// Checker for the LED matrix scan driver: predicts every scanned column and compares it.
module led_matrix_scan_driver_checker import lmsd_pkg::*; #(
   parameter int PANEL_COLUMNS    = 32,
   parameter int HALF_ROWS        = 8,
   parameter int BRIGHTNESS_STEPS = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   input  logic                       req_tready,
   input  logic [REQ_TDATA_WIDTH-1:0] req_tdata,
   input  logic                       req_tuser,
   input  logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   input  logic [RSP_TDATA_WIDTH-1:0] rsp_tdata,
   input  logic                       rsp_tlast,
   output int                         error_count,
   output int                         pending_columns,
   output int                         compared_columns
);

   localparam int PANEL_ROWS  = 2 * HALF_ROWS;
   localparam int STORE_DEPTH = PANEL_ROWS * PANEL_COLUMNS;
   localparam int MAX_REPORTS = 30;

   typedef struct packed {
      logic [RGB_WIDTH-1:0]      upper_rgb;
      logic [RGB_WIDTH-1:0]      lower_rgb;
      logic                      row_end;
      logic [ROW_ADDR_WIDTH-1:0] row_address;
   } column_result_type;

   colour_type        pixel_colours [STORE_DEPTH];
   int unsigned       scan_column;
   int unsigned       scan_row;
   int unsigned       brightness_step;
   column_result_type expected_columns [$];
   int                errors   = 0;
   int                compared = 0;

   function automatic logic [RGB_WIDTH-1:0] lit_components(input colour_type colour);
      logic [RGB_WIDTH-1:0] bits;
      bits[2] = (colour.red   >= brightness_step);
      bits[1] = (colour.green >= brightness_step);
      bits[0] = (colour.blue  >= brightness_step);
      return bits;
   endfunction

   // Works out the column that the next tick shifts out, then moves the scan on.
   function automatic column_result_type next_scan_column();
      column_result_type column;
      column.upper_rgb   = lit_components(pixel_colours[scan_row * PANEL_COLUMNS + scan_column]);
      column.lower_rgb   = lit_components(
         pixel_colours[(scan_row + HALF_ROWS) * PANEL_COLUMNS + scan_column]);
      column.row_end     = (scan_column + 1 >= PANEL_COLUMNS);
      column.row_address = column.row_end ? scan_row[ROW_ADDR_WIDTH-1:0] : '0;
      if (!column.row_end) begin
         scan_column++;
      end else begin
         scan_column = 0;
         if (scan_row + 1 >= HALF_ROWS) begin
            scan_row        = 0;
            brightness_step = (brightness_step + 1 >= BRIGHTNESS_STEPS) ? 0
                                                                        : brightness_step + 1;
         end else begin
            scan_row++;
         end
      end
      return column;
   endfunction

   function automatic void check_field(input string name, input int wanted, input int seen);
      if (wanted != seen) begin
         errors++;
         if (errors <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, wanted, seen);
      end
   endfunction

   always @(posedge clock) begin
      column_result_type seen;
      column_result_type wanted;
      int unsigned       row;
      int unsigned       column;
      if (reset) begin
         foreach (pixel_colours[i]) pixel_colours[i] = '0;
         scan_column     = 0;
         scan_row        = 0;
         brightness_step = 0;
         expected_columns.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            seen.upper_rgb   = rsp_tdata[2:0];
            seen.lower_rgb   = rsp_tdata[5:3];
            seen.row_address = rsp_tdata[8:6];
            seen.row_end     = rsp_tlast;
            if (expected_columns.size() == 0) begin
               errors++;
               if (errors <= MAX_REPORTS)
                  $display("%0t: unexpected result, expected none, got 'h%0h", $time, seen);
            end else begin
               wanted = expected_columns.pop_front();
               check_field("upper_rgb",   int'(wanted.upper_rgb),   int'(seen.upper_rgb));
               check_field("lower_rgb",   int'(wanted.lower_rgb),   int'(seen.lower_rgb));
               check_field("row_end",     int'(wanted.row_end),     int'(seen.row_end));
               check_field("row_address", int'(wanted.row_address), int'(seen.row_address));
               compared++;
            end
         end
         if (req_tvalid && req_tready) begin
            if (mode_type'(req_tuser) == MODE_TICK) begin
               expected_columns.push_back(next_scan_column());
            end else begin
               row    = 32'(req_tdata[4:0]);
               column = 32'(req_tdata[9:5]);
               // Writes outside the panel leave the frame store untouched.
               if (row < PANEL_ROWS && column < PANEL_COLUMNS)
                  pixel_colours[row * PANEL_COLUMNS + column] =
                     '{red: req_tdata[17:10], green: req_tdata[25:18], blue: req_tdata[33:26]};
            end
         end
      end
      error_count      <= errors;
      pending_columns  <= expected_columns.size();
      compared_columns <= compared;
   end

endmodule

// ===== dv/tb_led_matrix_scan_driver.sv =====
// Testbench top for the LED matrix scan driver: stimulus, flow control and verdict.
module tb_led_matrix_scan_driver;
   import lmsd_pkg::*;

   localparam int PANEL_COLUMNS    = 32;
   localparam int HALF_ROWS        = 8;
   localparam int BRIGHTNESS_STEPS = 4;
   localparam int TICKS_PER_STEP   = PANEL_COLUMNS * HALF_ROWS;
   localparam int TICKS_PER_CYCLE  = TICKS_PER_STEP * BRIGHTNESS_STEPS;
   // The random part keeps ticking until one whole brightness cycle has wrapped.
   localparam int TOTAL_TICKS      = TICKS_PER_CYCLE + 16;
   // Margin waited after the checker has no results outstanding.
   localparam int DRAIN_CYCLES     = 8;
   localparam int CYCLE_LIMIT      = 600000;

   logic                       clock      = 1'b0;
   logic                       reset      = 1'b1;
   logic                       req_tvalid = 1'b0;
   logic                       req_tready;
   logic [REQ_TDATA_WIDTH-1:0] req_tdata  = '0;
   logic                       req_tuser  = 1'b0;
   logic                       rsp_tvalid;
   logic                       rsp_tready = 1'b0;
   logic [RSP_TDATA_WIDTH-1:0] rsp_tdata;
   logic                       rsp_tlast;

   int   error_count;
   int   pending_columns;
   int   compared_columns;
   int   cycle_count   = 0;
   int   ticks_sent    = 0;
   int   writes_sent   = 0;
   int   rsp_stall_left = 0;
   logic no_idling     = 1'b0;

   led_matrix_scan_driver #(
      .PANEL_COLUMNS    (PANEL_COLUMNS),
      .HALF_ROWS        (HALF_ROWS),
      .BRIGHTNESS_STEPS (BRIGHTNESS_STEPS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // The checker watches both channels, keeps its own frame store and scan
   // position, and reports its failure count back here.
   led_matrix_scan_driver_checker #(
      .PANEL_COLUMNS    (PANEL_COLUMNS),
      .HALF_ROWS        (HALF_ROWS),
      .BRIGHTNESS_STEPS (BRIGHTNESS_STEPS)
   ) column_checker (
      .clock            (clock),
      .reset            (reset),
      .req_tvalid       (req_tvalid),
      .req_tready       (req_tready),
      .req_tdata        (req_tdata),
      .req_tuser        (req_tuser),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_tdata        (rsp_tdata),
      .rsp_tlast        (rsp_tlast),
      .error_count      (error_count),
      .pending_columns  (pending_columns),
      .compared_columns (compared_columns)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Idle lengths shared by both sides: mostly none or short, now and then a
   // long one, and nothing at all while a no-idling stretch is in force.
   function automatic int idle_length();
      int roll;
      roll = $urandom_range(0, 99);
      if (no_idling || roll < 55) return 0;
      if (roll < 93) return $urandom_range(1, 3);
      return $urandom_range(6, 40);
   endfunction

   // Levels cluster around the brightness steps so that the threshold compare
   // is exercised on both sides; the extremes and full-range values also appear.
   function automatic logic [LEVEL_WIDTH-1:0] random_level();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 50) return 8'($urandom_range(0, 4));
      if (roll < 60) return 8'hFF;
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic colour_type random_colour();
      colour_type colour;
      colour.red   = random_level();
      colour.green = random_level();
      colour.blue  = random_level();
      return colour;
   endfunction

   // Presents one item, holds it until the block takes it, then may leave a gap.
   // The valid is only lowered when a gap follows, so back-to-back items keep it
   // high without a second assignment in the same step.
   task automatic send_panel_item(input mode_type mode, input logic [4:0] row,
                                  input logic [4:0] column, input colour_type colour);
      int gap;
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= REQ_TDATA_WIDTH'({colour.blue, colour.green, colour.red, column, row});
      do @(posedge clock); while (!req_tready);
      if (mode == MODE_TICK) ticks_sent++;
      else writes_sent++;
      gap = idle_length();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // The result side stalls at random: a nonzero draw holds tready low until the countdown
   // of the drawn length runs out; a zero draw keeps it high.
   always @(posedge clock) begin
      if (rsp_stall_left > 0) begin
         rsp_stall_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_stall_left = idle_length();
         rsp_tready <= (rsp_stall_left == 0);
      end
   end

   // Watchdog: a lost result or a hung handshake ends the run here.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Timed out after %0d cycles with %0d results outstanding.",
               cycle_count, pending_columns);
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      int         scan_row_now;
      logic [4:0] row;
      logic [4:0] column;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed part. The block clears its store after reset with tready low,
      // which the handshake wait absorbs. Extremes of the levels, both panel
      // halves, the last column, and writes to rows beyond the panel that must
      // not alias onto the rows that a tick later reads.
      send_panel_item(MODE_WRITE, 5'd0,  5'd0,  '{red: 8'hFF, green: 8'h00, blue: 8'h01});
      send_panel_item(MODE_WRITE, 5'd8,  5'd0,  '{red: 8'h02, green: 8'h03, blue: 8'h00});
      send_panel_item(MODE_WRITE, 5'd16, 5'd0,  '{red: 8'hFF, green: 8'hFF, blue: 8'hFF});
      send_panel_item(MODE_WRITE, 5'd31, 5'd31, '{red: 8'hFF, green: 8'hFF, blue: 8'hFF});
      send_panel_item(MODE_WRITE, 5'd7,  5'd31, '{red: 8'h01, green: 8'h01, blue: 8'h01});
      send_panel_item(MODE_WRITE, 5'd15, 5'd31, '{red: 8'h00, green: 8'hFF, blue: 8'h04});
      send_panel_item(MODE_WRITE, 5'd0,  5'd1,  '{red: 8'h03, green: 8'h02, blue: 8'h01});
      send_panel_item(MODE_WRITE, 5'd24, 5'd1,  '{red: 8'h80, green: 8'h40, blue: 8'hFF});
      // At brightness step zero every component is lit, black pixels included.
      repeat (16) send_panel_item(MODE_TICK, 5'd0, 5'd0, '0);

      // Random part: mostly ticks so that the scan walks every row and wraps the
      // brightness step, with pixel writes mixed in. Half of the writes land just
      // ahead of the scan in the current row of either half, so that fresh
      // colours are read back at every step; the rest go anywhere, rows beyond
      // the panel included. Tick items carry random data, which the block ignores.
      while (ticks_sent < TOTAL_TICKS) begin
         if ((ticks_sent + writes_sent) % 128 == 0)
            no_idling <= ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 31) == 0) begin
            if ($urandom_range(0, 1) == 0) begin
               scan_row_now = (ticks_sent / PANEL_COLUMNS) % HALF_ROWS;
               row    = 5'(scan_row_now + ($urandom_range(0, 1) ? HALF_ROWS : 0));
               column = 5'((ticks_sent + $urandom_range(0, 7)) % PANEL_COLUMNS);
            end else begin
               row    = 5'($urandom_range(0, 31));
               column = 5'($urandom_range(0, 31));
            end
            send_panel_item(MODE_WRITE, row, column, random_colour());
         end else begin
            send_panel_item(MODE_TICK, 5'($urandom), 5'($urandom), random_colour());
         end
      end
      req_tvalid <= 1'b0;
      no_idling  <= 1'b0;

      // The checker's counts are registered, so step past the edge that updates them before waiting on them.
      @(posedge clock);
      while (pending_columns != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d scan ticks over %0d full brightness cycles and %0d pixel writes.",
               ticks_sent, ticks_sent / TICKS_PER_CYCLE, writes_sent);
      $display("Compared %0d column results; %0d mismatches seen.",
               compared_columns, error_count);
      if (error_count == 0 && pending_columns == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
